### hdl/cmp_pkg.sv
package cmp_pkg;

    // Cell geometry
    localparam int MAX_CELL_SIDE = 1024;
    localparam int SIDE_W        = 11;              // register and side width
    localparam int CNT_W         = 10;              // column / row counter width
    localparam int OFS_W         = CNT_W + 2;       // signed half-pixel offset
    localparam int SQ_W          = 2 * (OFS_W - 1); // one squared offset
    localparam int SUM_W         = SQ_W + 1;        // dx*dx + dy*dy
    localparam int FRAC_SHIFT    = 16;              // 8 fraction bits of root

    // Square root chain
    localparam int ROOT_W = (SUM_W + FRAC_SHIFT + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;
    localparam int CUR_W  = REM_W + 2;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 2'd1;
    localparam logic [SIDE_W-1:0]    SIDE_RESET      = 11'd64;

    // Pixel and geometry data that rides along with the root
    typedef struct packed {
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [7:0]        alpha;
        logic              last;
        logic [SIDE_W-1:0] side;
    } t_side;

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] res;
        if (v == '0) begin
            res = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_CELL_SIDE)) begin
            res = SIDE_W'(MAX_CELL_SIDE);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

### hdl/circle_mask_premultiply_core.sv
// Pipeline: 3 geometry stages, 20 square-root cells and 4 shading stages between an
//   accepted input transaction and its output transaction.
// Throughput: one pixel per cycle; the whole pipeline holds while the output
//   register is full and stalled, set by that single output register.
// Reset (i_rst_n low, synchronous): pipeline emptied, column/row counters cleared,
//   cell width and height back to 64.
module circle_mask_premultiply_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel input
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_in_red,
    input  logic [7:0]                      i_in_green,
    input  logic [7:0]                      i_in_blue,
    input  logic [7:0]                      i_in_alpha,
    // pixel output
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_out_red,
    output logic [7:0]                      o_out_green,
    output logic [7:0]                      o_out_blue,
    output logic [7:0]                      o_out_alpha,
    output logic                            o_out_last,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cmp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cmp_pkg::SIDE_W-1:0]      i_cfg_data
);

    localparam int N_CELLS = cmp_pkg::ROOT_W;

    // Config registers. Writes are always taken; unknown indexes are dropped.
    logic [cmp_pkg::SIDE_W-1:0] r_cell_width;
    logic [cmp_pkg::SIDE_W-1:0] r_cell_height;

    // Global advance: every stage moves together unless the output register
    // holds a transaction the sink is stalling.
    logic adv;

    logic                       geom_valid;
    cmp_pkg::t_side             geom_side;
    logic [cmp_pkg::SUM_W-1:0]  geom_sum;

    // square-root chain taps, index 0 is the chain input
    logic                       c_valid [N_CELLS+1];
    logic [cmp_pkg::REM_W-1:0]  c_rem   [N_CELLS+1];
    logic [cmp_pkg::ROOT_W-1:0] c_root  [N_CELLS+1];
    logic [cmp_pkg::RAD_W-1:0]  c_rad   [N_CELLS+1];
    cmp_pkg::t_side             c_side  [N_CELLS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width  <= cmp_pkg::SIDE_RESET;
            r_cell_height <= cmp_pkg::SIDE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == cmp_pkg::REG_CELL_WIDTH) begin
                r_cell_width <= i_cfg_data;
            end else if (i_cfg_index == cmp_pkg::REG_CELL_HEIGHT) begin
                r_cell_height <= i_cfg_data;
            end
        end
    end

    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    // Counters, half-pixel offsets, squared distance
    cmp_geom u_geom (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (i_valid),
        .i_red         (i_in_red),
        .i_green       (i_in_green),
        .i_blue        (i_in_blue),
        .i_alpha       (i_in_alpha),
        .i_cell_width  (r_cell_width),
        .i_cell_height (r_cell_height),
        .o_valid       (geom_valid),
        .o_side        (geom_side),
        .o_sum         (geom_sum)
    );

    // Radicand is the squared distance with 16 zero fraction bits, so the
    // root comes out in half pixels with 8 fraction bits.
    assign c_valid[0] = geom_valid;
    assign c_rem[0]   = '0;
    assign c_root[0]  = '0;
    assign c_rad[0]   = cmp_pkg::RAD_W'({geom_sum, cmp_pkg::FRAC_SHIFT'(0)});
    assign c_side[0]  = geom_side;

    // One root bit per cell, most significant first
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        cmp_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (c_valid[k]),
            .i_rem   (c_rem[k]),
            .i_root  (c_root[k]),
            .i_rad   (c_rad[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_root  (c_root[k+1]),
            .o_rad   (c_rad[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    // Coverage, premultiply, rounding, output register.
    // The final remainder and radicand taps are not needed past the chain.
    cmp_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (c_valid[N_CELLS] && (c_rad[N_CELLS] == '0 || c_rem[N_CELLS] >= '0)),
        .i_root  (c_root[N_CELLS]),
        .i_side  (c_side[N_CELLS]),
        .o_valid (o_valid),
        .o_red   (o_out_red),
        .o_green (o_out_green),
        .o_blue  (o_out_blue),
        .o_alpha (o_out_alpha),
        .o_last  (o_out_last)
    );

endmodule

### hdl/cmp_geom.sv
module cmp_geom (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic [7:0]                    i_alpha,
    input  logic [cmp_pkg::SIDE_W-1:0]    i_cell_width,
    input  logic [cmp_pkg::SIDE_W-1:0]    i_cell_height,
    output logic                          o_valid,
    output cmp_pkg::t_side                o_side,
    output logic [cmp_pkg::SUM_W-1:0]     o_sum
);

    logic [cmp_pkg::CNT_W-1:0]          r_col, n_col;
    logic [cmp_pkg::CNT_W-1:0]          r_row, n_row;
    logic [cmp_pkg::SIDE_W-1:0]         w_eff, h_eff;
    logic                               end_row, last;
    logic signed [cmp_pkg::OFS_W-1:0]   dx, dy;
    logic signed [2*cmp_pkg::OFS_W-1:0] sqx_full, sqy_full;
    cmp_pkg::t_side                     side_in;

    // stage 1: offsets
    logic                               r_v1;
    logic signed [cmp_pkg::OFS_W-1:0]   r_dx, r_dy;
    cmp_pkg::t_side                     r_side1;
    // stage 2: squares
    logic                               r_v2;
    logic [cmp_pkg::SQ_W-1:0]           r_sqx, r_sqy;
    cmp_pkg::t_side                     r_side2;
    // stage 3: sum
    logic                               r_v3;
    logic [cmp_pkg::SUM_W-1:0]          r_sum;
    cmp_pkg::t_side                     r_side3;

    assign w_eff = cmp_pkg::eff_side(i_cell_width);
    assign h_eff = cmp_pkg::eff_side(i_cell_height);

    assign end_row = {1'b0, r_col} >= (w_eff - cmp_pkg::SIDE_W'(1));
    assign last    = end_row && ({1'b0, r_row} >= (h_eff - cmp_pkg::SIDE_W'(1)));

    // half-pixel offsets from the cell center
    assign dx = $signed({1'b0, r_col, 1'b1}) - $signed({1'b0, w_eff});
    assign dy = $signed({1'b0, r_row, 1'b1}) - $signed({1'b0, h_eff});

    always_comb begin
        side_in.red   = i_red;
        side_in.green = i_green;
        side_in.blue  = i_blue;
        side_in.alpha = i_alpha;
        side_in.last  = last;
        side_in.side  = (w_eff < h_eff) ? w_eff : h_eff;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_valid && i_adv) begin
            if (last) begin
                n_col = '0;
                n_row = '0;
            end else if (end_row) begin
                n_col = '0;
                n_row = r_row + cmp_pkg::CNT_W'(1);
            end else begin
                n_col = r_col + cmp_pkg::CNT_W'(1);
            end
        end
    end

    assign sqx_full = r_dx * r_dx;
    assign sqy_full = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_adv) begin
                r_v1 <= i_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx    <= dx;
            r_dy    <= dy;
            r_side1 <= side_in;
            r_sqx   <= sqx_full[cmp_pkg::SQ_W-1:0];
            r_sqy   <= sqy_full[cmp_pkg::SQ_W-1:0];
            r_side2 <= r_side1;
            r_sum   <= {1'b0, r_sqx} + {1'b0, r_sqy};
            r_side3 <= r_side2;
        end
    end

    assign o_valid = r_v3;
    assign o_side  = r_side3;
    assign o_sum   = r_sum;

endmodule

### hdl/cmp_sqrt_cell.sv
module cmp_sqrt_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  logic [cmp_pkg::REM_W-1:0]      i_rem,
    input  logic [cmp_pkg::ROOT_W-1:0]     i_root,
    input  logic [cmp_pkg::RAD_W-1:0]      i_rad,
    input  cmp_pkg::t_side                 i_side,
    output logic                           o_valid,
    output logic [cmp_pkg::REM_W-1:0]      o_rem,
    output logic [cmp_pkg::ROOT_W-1:0]     o_root,
    output logic [cmp_pkg::RAD_W-1:0]      o_rad,
    output cmp_pkg::t_side                 o_side
);

    logic [cmp_pkg::CUR_W-1:0]  cur, trial, diff;
    logic                       take;
    logic                       r_valid;
    logic [cmp_pkg::REM_W-1:0]  r_rem;
    logic [cmp_pkg::ROOT_W-1:0] r_root;
    logic [cmp_pkg::RAD_W-1:0]  r_rad;
    cmp_pkg::t_side             r_side;

    // bring down the next two radicand bits, try root*4+1
    assign cur   = {i_rem, i_rad[cmp_pkg::RAD_W-1 -: 2]};
    assign trial = cmp_pkg::CUR_W'({i_root, 2'b01});
    assign take  = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= take ? diff[cmp_pkg::REM_W-1:0] : cur[cmp_pkg::REM_W-1:0];
            r_root <= {i_root[cmp_pkg::ROOT_W-2:0], take};
            r_rad  <= {i_rad[cmp_pkg::RAD_W-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule

### hdl/cmp_shade.sv
module cmp_shade (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [cmp_pkg::ROOT_W-1:0]  i_root,
    input  cmp_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [7:0]                  o_red,
    output logic [7:0]                  o_green,
    output logic [7:0]                  o_blue,
    output logic [7:0]                  o_alpha,
    output logic                        o_last
);

    localparam int DIFF_W = cmp_pkg::ROOT_W + 1;

    logic signed [DIFF_W-1:0] diff;
    logic [8:0]               cov;
    logic [23:0]              cp_r, cp_g, cp_b;
    logic [15:0]              a_rnd;
    logic [7:0]               q_r, q_g, q_b;

    // coverage stage
    logic           r_v1;
    logic [8:0]     r_cov;
    cmp_pkg::t_side r_side1;
    // alpha * coverage
    logic           r_v2;
    logic [15:0]    r_prod;
    cmp_pkg::t_side r_side2;
    // color * alpha * coverage, scaled down by 256
    logic           r_v3;
    logic [15:0]    r_t_r, r_t_g, r_t_b;
    logic [7:0]     r_alpha3;
    logic           r_last3;
    // output register
    logic           r_v4;
    logic [7:0]     r_red, r_green, r_blue, r_alpha;
    logic           r_last;

    // radius*2 in half pixels, 8 fraction bits, minus the root
    assign diff = $signed({1'b0, cmp_pkg::ROOT_W'({i_side.side, 8'd0})}) -
                  $signed({1'b0, i_root});

    always_comb begin
        if (diff <= 0) begin
            cov = 9'd0;
        end else if (diff >= DIFF_W'(512)) begin
            cov = 9'd256;
        end else begin
            cov = {1'b0, diff[8:1]};
        end
    end

    assign cp_r  = (24'(r_side2.red)   * 24'(r_prod)) + 24'd32640;
    assign cp_g  = (24'(r_side2.green) * 24'(r_prod)) + 24'd32640;
    assign cp_b  = (24'(r_side2.blue)  * 24'(r_prod)) + 24'd32640;
    assign a_rnd = r_prod + 16'd128;

    // floor(t / 255): reciprocal estimate, then one correction step
    function automatic logic [7:0] div255(input logic [15:0] t);
        logic [23:0] est;
        logic [7:0]  q0;
        logic [15:0] rem;
        est = {t, 8'd0} + 24'(t);
        q0  = est[23:16];
        rem = t - ({q0, 8'd0} - 16'(q0));
        return (rem >= 16'd255) ? q0 + 8'd1 : q0;
    endfunction

    assign q_r = div255(r_t_r);
    assign q_g = div255(r_t_g);
    assign q_b = div255(r_t_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cov    <= cov;
            r_side1  <= i_side;
            r_prod   <= {8'd0, r_side1.alpha} * {7'd0, r_cov};
            r_side2  <= r_side1;
            r_t_r    <= cp_r[23:8];
            r_t_g    <= cp_g[23:8];
            r_t_b    <= cp_b[23:8];
            r_alpha3 <= a_rnd[15:8];
            r_last3  <= r_side2.last;
            r_red    <= q_r;
            r_green  <= q_g;
            r_blue   <= q_b;
            r_alpha  <= r_alpha3;
            r_last   <= r_last3;
        end
    end

    assign o_valid = r_v4;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;
    assign o_last  = r_last;

endmodule

### bench/premult_check_pkg.sv
package premult_check_pkg;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } shaded_pixel_t;

    // Scoreboard: tracks cell geometry, computes the masked premultiplied
    // pixel for each accepted input and checks output transactions in order.
    class premult_checker;
        logic [cmp_pkg::SIDE_W-1:0] width_reg;
        logic [cmp_pkg::SIDE_W-1:0] height_reg;
        int unsigned                col_count;
        int unsigned                row_count;
        shaded_pixel_t              expected_pixels[$];
        int unsigned                error_count;

        function new();
            width_reg   = cmp_pkg::SIDE_RESET;
            height_reg  = cmp_pkg::SIDE_RESET;
            col_count   = 0;
            row_count   = 0;
            error_count = 0;
        endfunction

        // 0 behaves as 1, oversize saturates
        function int unsigned clamp_side(logic [cmp_pkg::SIDE_W-1:0] v);
            if (v == '0) begin
                return 1;
            end
            if (v > cmp_pkg::MAX_CELL_SIDE) begin
                return cmp_pkg::MAX_CELL_SIDE;
            end
            return v;
        endfunction

        // floor(sqrt(n)), built one bit at a time
        function u64_t root_floor(u64_t n);
            u64_t res;
            u64_t cand;
            res = 0;
            for (int i = 31; i >= 0; i--) begin
                cand = res | (u64_t'(1) << i);
                if (cand * cand <= n) begin
                    res = cand;
                end
            end
            return res;
        endfunction

        function void write_register(logic [cmp_pkg::CFG_IDX_W-1:0] idx,
                                     logic [cmp_pkg::SIDE_W-1:0] data);
            if (idx == cmp_pkg::REG_CELL_WIDTH) begin
                width_reg = data;
            end else if (idx == cmp_pkg::REG_CELL_HEIGHT) begin
                height_reg = data;
            end
        endfunction

        function int unsigned cell_pixels();
            return clamp_side(width_reg) * clamp_side(height_reg);
        endfunction

        // pixels still needed to reach the final pixel of the current cell
        function int pixels_to_cell_end();
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int          n;
            w = clamp_side(width_reg);
            h = clamp_side(height_reg);
            c = col_count;
            r = row_count;
            n = 0;
            while (n < 4096) begin
                n++;
                if (c >= w - 1) begin
                    if (r >= h - 1) begin
                        return n;
                    end
                    c = 0;
                    r++;
                end else begin
                    c++;
                end
            end
            return n;
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
            int unsigned   w;
            int unsigned   h;
            int unsigned   side_min;
            longint        dx;
            longint        dy;
            longint        diff;
            u64_t          sum;
            u64_t          root_q;
            u64_t          cov;
            u64_t          prod;
            bit            end_row;
            bit            last;
            shaded_pixel_t px;

            w  = clamp_side(width_reg);
            h  = clamp_side(height_reg);
            // offsets in half pixels from the cell centre
            dx = 2 * longint'(col_count) + 1 - longint'(w);
            dy = 2 * longint'(row_count) + 1 - longint'(h);
            sum  = u64_t'(dx * dx + dy * dy);
            root_q = root_floor(sum << 16);
            side_min = (w < h) ? w : h;
            diff = longint'(side_min) * 256 - longint'(root_q);
            if (diff <= 0) begin
                cov = 0;
            end else if (diff >= 512) begin
                cov = 256;
            end else begin
                cov = u64_t'(diff) >> 1;
            end

            prod     = u64_t'(a) * cov;
            px.alpha = 8'((prod + 128) >> 8);
            px.red   = 8'((2 * u64_t'(r) * prod + 65280) / 130560);
            px.green = 8'((2 * u64_t'(g) * prod + 65280) / 130560);
            px.blue  = 8'((2 * u64_t'(b) * prod + 65280) / 130560);

            end_row = (col_count >= w - 1);
            last    = end_row && (row_count >= h - 1);
            px.last = last;
            expected_pixels.push_back(px);

            if (last) begin
                col_count = 0;
                row_count = 0;
            end else if (end_row) begin
                col_count = 0;
                row_count++;
            end else begin
                col_count++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void report_field(string field, int want, int got, realtime stamp);
            error_count++;
            $display("%0.1f ns: %s expected %0d, actual %0d", stamp, field, want, got);
        endfunction

        function void check_pixel(shaded_pixel_t got, realtime stamp);
            shaded_pixel_t want;
            if (expected_pixels.size() == 0) begin
                error_count++;
                $display("%0.1f ns: output transaction with nothing pending, actual %h",
                         stamp, got);
                return;
            end
            want = expected_pixels.pop_front();
            if (want.red != got.red) begin
                report_field("out_red", want.red, got.red, stamp);
            end
            if (want.green != got.green) begin
                report_field("out_green", want.green, got.green, stamp);
            end
            if (want.blue != got.blue) begin
                report_field("out_blue", want.blue, got.blue, stamp);
            end
            if (want.alpha != got.alpha) begin
                report_field("out_alpha", want.alpha, got.alpha, stamp);
            end
            if (want.last != got.last) begin
                report_field("out_last", want.last, got.last, stamp);
            end
        endfunction
    endclass

endpackage

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cmp_pkg::*;
    import premult_check_pkg::*;

    localparam int DIRECTED_PIXELS = 19;
    localparam int TOTAL_PIXELS    = DIRECTED_PIXELS + 1750;
    localparam int TAIL_START      = TOTAL_PIXELS - 250;  // no idling from here on
    localparam int LATENCY         = 27;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int MAX_PHASE       = 400;                 // cap on pixels per phase

    // indexes with no register behind them; writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [7:0]           i_in_red    = '0;
    logic [7:0]           i_in_green  = '0;
    logic [7:0]           i_in_blue   = '0;
    logic [7:0]           i_in_alpha  = '0;
    logic                 i_stall     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_CELL_WIDTH;
    logic [SIDE_W-1:0]    i_cfg_data  = '0;

    logic                 o_stall;
    logic                 o_valid;
    logic [7:0]           o_out_red;
    logic [7:0]           o_out_green;
    logic [7:0]           o_out_blue;
    logic [7:0]           o_out_alpha;
    logic                 o_out_last;
    logic                 o_cfg_ready;

    premult_checker shade_sb;

    int unsigned pixels_sent = 0;
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;
    bit          in_idle_on  = 1'b1;
    bit          out_idle_on = 1'b1;
    bit          quiet       = 1'b0;   // tail of the run: both sides run flat out

    always #6 i_clk = ~i_clk;

    circle_mask_premultiply_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_out_last  (o_out_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Downstream backpressure: stall bursts at random.
    always @(posedge i_clk) begin
        if (!quiet && stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (out_idle_on && !quiet && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(0, 9);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Output monitor. Sampled mid-cycle: everything is stable there, and the
    // transaction completes at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            shade_sb.check_pixel(shaded_pixel_t'({o_out_red, o_out_green, o_out_blue,
                                                  o_out_alpha, o_out_last}), $realtime);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Channel value with a bias toward the extremes.
    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Register value at or beyond the edges of the legal size range.
    function automatic logic [SIDE_W-1:0] edge_side();
        case ($urandom_range(0, 4))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd1024;
            3:       return 11'd1025;
            default: return 11'd2047;
        endcase
    endfunction

    // Called at a rising edge; returns at the rising edge that took the pixel.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
        int unsigned gap;
        if (in_idle_on && !quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_in_red   <= r;
        i_in_green <= g;
        i_in_blue  <= b;
        i_in_alpha <= a;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        shade_sb.note_pixel(r, g, b, a);
        pixels_sent++;
        @(posedge i_clk);
    endtask

    task automatic send_random_pixel();
        send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIDE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        shade_sb.write_register(idx, data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop feeding and wait until every pixel in flight has come out.
    task automatic drain();
        i_valid <= 1'b0;
        while (shade_sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int                n;
        logic [SIDE_W-1:0] w_new;
        logic [SIDE_W-1:0] h_new;
        bit                keep_size;

        shade_sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default 64x64 cell, channel extremes and alternating bits.
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
        send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
        drain();

        // Zero size acts as one: every pixel is the last, and the size shrinks
        // while the counters sit in the middle of the old cell.
        write_reg(REG_CELL_WIDTH, 11'd0);
        write_reg(REG_CELL_HEIGHT, 11'd0);
        repeat (3) send_pixel(8'hFF, 8'h80, 8'h01, 8'hFF);
        drain();

        // Oversize width saturates at the maximum side.
        write_reg(REG_CELL_WIDTH, 11'd2047);
        write_reg(REG_CELL_HEIGHT, 11'd1);
        repeat (3) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drain();

        // Writes to unused indexes are dropped; 3x3 cell entered from stale counters, center fully covered.
        write_reg(REG_CELL_WIDTH, 11'd3);
        write_reg(REG_CELL_HEIGHT, 11'd3);
        write_reg(REG_SPARE_2, 11'd7);
        write_reg(REG_SPARE_3, 11'd2047);
        repeat (9) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // Random phases: reconfigure while idle, then mostly finish cells,
        // sometimes stop mid-cell so the next size lands on stale counters.
        while (pixels_sent < TOTAL_PIXELS) begin
            drain();
            quiet       = (pixels_sent >= TAIL_START);
            in_idle_on  = ($urandom_range(0, 9) < 7);
            out_idle_on = ($urandom_range(0, 9) < 7);
            keep_size   = 1'b0;
            case ($urandom_range(0, 9))
                6: begin
                    w_new = edge_side();
                    h_new = 11'($urandom_range(1, 3));
                end
                7: begin
                    w_new = 11'($urandom_range(1, 3));
                    h_new = edge_side();
                end
                8: begin
                    w_new = 11'($urandom_range(0, 2047));
                    h_new = 11'($urandom_range(0, 2047));
                end
                9: begin
                    keep_size = 1'b1;
                    w_new     = '0;
                    h_new     = '0;
                end
                default: begin
                    w_new = 11'($urandom_range(1, 12));
                    h_new = 11'($urandom_range(1, 12));
                end
            endcase
            if (!keep_size) begin
                if ($urandom_range(0, 3) != 0) begin
                    write_reg(REG_CELL_WIDTH, w_new);
                end
                write_reg(REG_CELL_HEIGHT, h_new);
            end
            if ($urandom_range(0, 5) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          11'($urandom_range(0, 2047)));
            end

            if ($urandom_range(0, 4) != 0) begin
                n = shade_sb.pixels_to_cell_end();
                if (shade_sb.cell_pixels() <= 100) begin
                    n += shade_sb.cell_pixels() * $urandom_range(0, 3);
                end
                if (n > MAX_PHASE) begin
                    n = $urandom_range(1, 60);
                end
            end else begin
                n = $urandom_range(1, 60);
            end
            repeat (n) send_random_pixel();
        end

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (shade_sb.error_count == 0 && shade_sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hdl/cmp_pkg.sv
hdl/cmp_geom.sv
hdl/cmp_sqrt_cell.sv
hdl/cmp_shade.sv
hdl/circle_mask_premultiply_core.sv
bench/premult_check_pkg.sv
bench/tb.sv
